FILE: sv/serial_line_editor_command_match_defines.svh
// assertion macros used by the line editor back end
`ifndef SERIAL_LINE_EDITOR_COMMAND_MATCH_DEFINES_SVH
`define SERIAL_LINE_EDITOR_COMMAND_MATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SLE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line editor assertion failed");

// next-cycle implication
`define SLE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line editor assertion failed");

`else

`define SLE_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SLE_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

  // terminal characters
  localparam logic [7:0] CH_BELL     = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  // result kinds and command codes
  localparam logic       KIND_TX      = 1'b0;
  localparam logic       KIND_REPORT  = 1'b1;
  localparam logic [1:0] CMD_EMPTY    = 2'd0;
  localparam logic [1:0] CMD_HELP     = 2'd1;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd2;

  // command queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // escape sequence tracking
  typedef enum logic [1:0] {
    ESC_NORMAL,
    ESC_SEEN,
    ESC_CSI
  } esc_phase_t;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_ECHO,
    OP_BELL,
    OP_ERASE,
    OP_EOL
  } op_t;

  typedef struct packed {
    op_t        kind;
    logic [7:0] data;
  } cmd_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_SCAN,
    ST_REPORT
  } back_state_t;

  // characters of the help keyword
  function automatic logic [7:0] help_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h68;
      2'd1: c = 8'h65;
      2'd2: c = 8'h6C;
      default: c = 8'h70;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sle_front #(
  parameter int LINE_DEPTH = 128,
  localparam int LW = $clog2(LINE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output sle_pkg::cmd_t      q_cmd,
  output logic [LW-1:0]      q_len
);
  import sle_pkg::*;

  esc_phase_t    phase_r, phase_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          acc;
  logic          printable;

  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign printable = (in_rx_byte >= CH_SPACE) && (in_rx_byte <= CH_TILDE);

  // escape phase and line length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ESC_NORMAL;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
    end
  end

  // classify each accepted byte
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    q_push    = 1'b0;
    q_cmd     = '{kind: OP_BELL, data: CH_BELL};
    q_len     = len_r;
    if (acc) begin
      unique case (phase_r)
        ESC_SEEN: begin
          phase_nxt = (in_rx_byte == CH_LBRACKET) ? ESC_CSI : ESC_NORMAL;
        end
        ESC_CSI: begin
          phase_nxt = ESC_NORMAL;
        end
        default: begin
          phase_nxt = ESC_NORMAL;
          if (in_rx_byte == CH_ESC) begin
            phase_nxt = ESC_SEEN;
          end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
            q_push  = 1'b1;
            q_cmd   = '{kind: OP_EOL, data: in_rx_byte};
            len_nxt = '0;
          end else if (in_rx_byte == CH_BS || in_rx_byte == CH_DEL) begin
            if (len_r != '0) begin
              q_push  = 1'b1;
              q_cmd   = '{kind: OP_ERASE, data: in_rx_byte};
              len_nxt = len_r - LW'(1);
            end
          end else if (printable) begin
            q_push = 1'b1;
            if (len_r != LW'(LINE_DEPTH - 1)) begin
              q_cmd   = '{kind: OP_ECHO, data: in_rx_byte};
              len_nxt = len_r + LW'(1);
            end else begin
              q_cmd = '{kind: OP_BELL, data: CH_BELL};
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sle_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sle_fifo #(
  parameter int WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  import sle_pkg::*;

  logic [WIDTH-1:0] q_mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == (QAW+1)'(QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (do_push && !do_pop) count_r <= count_r + (QAW+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (QAW+1)'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) q_mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

FILE: sv/sle_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_line_editor_command_match_defines.svh"

module sle_back #(
  parameter int LINE_DEPTH = 128,
  localparam int LW = $clog2(LINE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire sle_pkg::cmd_t q_cmd,
  input  wire logic [LW-1:0] q_len,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_item_kind,
  output logic [7:0]         out_tx_byte,
  output logic [1:0]         out_command,
  output logic [6:0]         out_token_start,
  output logic [6:0]         out_token_length,
  output logic               out_last
);
  import sle_pkg::*;

  back_state_t   state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [1:0]    seq_r, seq_nxt;

  // line store and scan
  logic [7:0]    line_mem [LINE_DEPTH];
  logic [7:0]    rd_data_r;
  logic [LW-1:0] scan_addr_r, scan_addr_nxt;
  logic [LW-1:0] rd_pos_r, rd_pos_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          in_tok_r, in_tok_nxt;
  logic [LW-1:0] tok_start_r, tok_start_nxt;
  logic [LW-1:0] tok_len_r, tok_len_nxt;
  logic          match_r, match_nxt;
  logic          wr_en;
  logic          done_tok, done_end;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [7:0]    out_tx_r, out_tx_nxt;
  logic [1:0]    out_cmd_r, out_cmd_nxt;
  logic [6:0]    out_start_r, out_start_nxt;
  logic [6:0]    out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;
  logic          slot, out_load;

  // per-op transmit sequence
  logic [7:0]    tx_sel;
  logic          tx_fin;

  assign slot  = !out_valid_r || out_ready;
  assign wr_en = q_pop && (q_cmd.kind == OP_ECHO);

  assign done_tok = rd_vld_r && in_tok_r && (rd_data_r == CH_SPACE);
  assign done_end = !rd_vld_r && (scan_addr_r >= len_r);

  // line store: written on echo, read during the end-of-line walk
  always_ff @(posedge clk) begin
    if (wr_en) line_mem[q_len] <= q_cmd.data;
    rd_data_r <= line_mem[scan_addr_r];
  end

  // transmit byte for the current op and step
  always_comb begin
    tx_sel = CH_BELL;
    tx_fin = 1'b1;
    unique case (op_r)
      OP_ECHO:  tx_sel = byte_r;
      OP_BELL:  tx_sel = CH_BELL;
      OP_ERASE: begin
        tx_sel = (seq_r == 2'd1) ? CH_SPACE : CH_BS;
        tx_fin = (seq_r == 2'd2);
      end
      default: begin
        tx_sel = (seq_r == 2'd0) ? CH_CR : CH_LF;
        tx_fin = (seq_r != 2'd0);
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    len_r       <= len_nxt;
    seq_r       <= seq_nxt;
    scan_addr_r <= scan_addr_nxt;
    rd_pos_r    <= rd_pos_nxt;
    in_tok_r    <= in_tok_nxt;
    tok_start_r <= tok_start_nxt;
    tok_len_r   <= tok_len_nxt;
    match_r     <= match_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tx_r    <= out_tx_nxt;
    out_cmd_r   <= out_cmd_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    len_nxt       = len_r;
    seq_nxt       = seq_r;
    scan_addr_nxt = scan_addr_r;
    rd_pos_nxt    = rd_pos_r;
    rd_vld_nxt    = 1'b0;
    in_tok_nxt    = in_tok_r;
    tok_start_nxt = tok_start_r;
    tok_len_nxt   = tok_len_r;
    match_nxt     = match_r;
    out_kind_nxt  = out_kind_r;
    out_tx_nxt    = out_tx_r;
    out_cmd_nxt   = out_cmd_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    out_load      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          op_nxt    = q_cmd.kind;
          byte_nxt  = q_cmd.data;
          len_nxt   = q_len;
          seq_nxt   = 2'd0;
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_TX;
          out_tx_nxt    = tx_sel;
          out_cmd_nxt   = CMD_EMPTY;
          out_start_nxt = '0;
          out_len_nxt   = '0;
          out_last_nxt  = tx_fin && (op_r != OP_EOL);
          seq_nxt       = seq_r + 2'd1;
          if (tx_fin) begin
            if (op_r == OP_EOL) begin
              state_nxt     = ST_SCAN;
              scan_addr_nxt = '0;
              in_tok_nxt    = 1'b0;
              tok_start_nxt = '0;
              tok_len_nxt   = '0;
              match_nxt     = 1'b0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      ST_SCAN: begin
        if (done_tok || done_end) begin
          state_nxt = ST_REPORT;
        end else begin
          // issue the next read
          if (scan_addr_r < len_r) begin
            rd_vld_nxt    = 1'b1;
            rd_pos_nxt    = scan_addr_r;
            scan_addr_nxt = scan_addr_r + LW'(1);
          end
          // take the character read last cycle
          if (rd_vld_r) begin
            if (!in_tok_r) begin
              if (rd_data_r != CH_SPACE) begin
                in_tok_nxt    = 1'b1;
                tok_start_nxt = rd_pos_r;
                tok_len_nxt   = LW'(1);
                match_nxt     = (rd_data_r == help_char(2'd0));
              end
            end else begin
              tok_len_nxt = tok_len_r + LW'(1);
              if (tok_len_r < LW'(4)) begin
                match_nxt = match_r && (rd_data_r == help_char(tok_len_r[1:0]));
              end
            end
          end
        end
      end

      ST_REPORT: begin
        if (slot) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_REPORT;
          out_tx_nxt   = 8'h00;
          out_last_nxt = 1'b1;
          if (in_tok_r) begin
            out_cmd_nxt   = (tok_len_r == LW'(4) && match_r) ? CMD_HELP : CMD_UNKNOWN;
            out_start_nxt = 7'(tok_start_r);
            out_len_nxt   = 7'(tok_len_r);
          end else begin
            out_cmd_nxt   = CMD_EMPTY;
            out_start_nxt = '0;
            out_len_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // output valid tracking
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = out_kind_r;
  assign out_tx_byte      = out_tx_r;
  assign out_command      = out_cmd_r;
  assign out_token_start  = out_start_r;
  assign out_token_length = out_len_r;
  assign out_last         = out_last_r;

  // checks
  `SLE_ASSERT_IMP(a_scan_in_line, clk, rst_n, (state_r == ST_SCAN && rd_vld_r), (rd_pos_r < len_r))
  `SLE_ASSERT_IMP(a_tok_fits, clk, rst_n, (state_r == ST_SCAN && in_tok_r), (tok_len_r <= len_r))
  `SLE_ASSERT_IMP(a_scan_holds_lf, clk, rst_n, (state_r == ST_SCAN && out_valid_r), (!out_last_r && out_tx_r == CH_LF))
  `SLE_ASSERT_NXT(a_report_last, clk, rst_n, (state_r == ST_REPORT && out_load), (out_valid_r && out_last_r && out_kind_r == KIND_REPORT))

endmodule

`default_nettype wire

FILE: sv/serial_line_editor_command_match.sv
// Terminal line editor with first-token command matching.
// Input channel: in_valid/in_ready/in_rx_byte, one received terminal byte per
// transaction. Result channel: out_valid/out_ready plus item fields; each
// transaction is either a byte to transmit (item_kind 0) or a command report
// (item_kind 1), and out_last marks the final result caused by one input byte.
// A byte that causes nothing (escape sequence bytes, other control bytes,
// backspace on an empty line) produces no result transaction.
// An idle back end pops each queued command and loads its results into the
// output register; backspace gives three results, back to back while the
// receiver is ready. End of line gives CR, LF, then walks the stored line
// one character per cycle through the line store read port until the first
// token or the line ends; the command report then follows as the final
// result. A 4-entry command queue lets the input side keep accepting while
// the back end works or the receiver stalls.
// Reset clears the escape state, the line length, the queue and the output
// register; the line store keeps its contents and needs no clearing pass.
// When out_ready is low the pending result is held in the output register and
// the back end pops at most one more command; in_ready drops on a full queue.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor_command_match #(
  parameter int LINE_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_item_kind,
  output logic [7:0]      out_tx_byte,
  output logic [1:0]      out_command,
  output logic [6:0]      out_token_start,
  output logic [6:0]      out_token_length,
  output logic            out_last
);
  import sle_pkg::*;

  localparam int LW = $clog2(LINE_DEPTH);
  localparam int QW = $bits(cmd_t) + LW;

  logic          q_push, q_pop, q_full, q_empty;
  cmd_t          push_cmd, pop_cmd;
  logic [LW-1:0] push_len, pop_len;
  logic [QW-1:0] pop_data;

  // front: escape tracking and classification
  sle_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_len      (push_len)
  );

  // command queue between front and back
  sle_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_cmd, push_len}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign pop_cmd = cmd_t'(pop_data[QW-1:LW]);
  assign pop_len = pop_data[LW-1:0];

  // back: line store, echo sequences and report
  sle_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (pop_cmd),
    .q_len            (pop_len),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_tx_byte      (out_tx_byte),
    .out_command      (out_command),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
